/* sv/particle_radius_table_scaler_macros.svh */
// assertion macros shared by the radius scaler rtl
`ifndef PARTICLE_RADIUS_TABLE_SCALER_MACROS_SVH
`define PARTICLE_RADIUS_TABLE_SCALER_MACROS_SVH

// same-cycle implication
`define PRTS_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PRTS_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/prts_pkg.sv */
// shared types and constants for the particle radius scaler
`timescale 1ns / 1ps
package prts_pkg;

    localparam int TABLE_SIZE_DEF = 256;
    localparam int MAX_COMP_DEF   = 4;
    localparam int IN_W           = 176;
    localparam int CFG_AW         = 3;
    localparam int CFG_DW         = 32;
    localparam int SQ_W           = 64;
    localparam int ROOT_W         = 32;

    localparam logic [CFG_AW-1:0] REG_USE_SCALE = 3'd0;
    localparam logic [CFG_AW-1:0] REG_COMP_SEL  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_POINT     = 3'd2;
    localparam logic [CFG_AW-1:0] REG_TBL_EN    = 3'd3;
    localparam logic [CFG_AW-1:0] REG_TBL_SCALE = 3'd4;
    localparam logic [CFG_AW-1:0] REG_TBL_OFS   = 3'd5;
    localparam logic [CFG_AW-1:0] REG_SCALE     = 3'd6;
    localparam logic [CFG_AW-1:0] REG_TRI       = 3'd7;

    localparam logic [31:0] Q16_ONE      = 32'h0001_0000;
    localparam logic [6:0]  RADIUS_FLOOR = 7'd66;
    localparam logic [6:0]  RADIUS_GAIN  = 7'd100;

    typedef struct packed {
        logic               func;
        logic [7:0]         addr;
        logic [31:0]        tval;
        logic               mag;
        logic signed [32:0] sel_raw;
    } side_t;

endpackage

/* sv/prts_ram.sv */
// generic single-write, registered-read ram
`timescale 1ns / 1ps
module prts_ram
    import prts_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = TABLE_SIZE_DEF
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/prts_sq_lane.sv */
// one component lane: registered square of the magnitude
`timescale 1ns / 1ps
module prts_sq_lane
    import prts_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] comp,
    input  logic               active,
    output logic [SQ_W-1:0]    sq
);

    logic [31:0]     mag;
    logic [SQ_W-1:0] prod;

    // two's complement negate also covers the most negative code
    assign mag  = comp[31] ? (~comp + 32'd1) : comp;
    assign prod = mag * mag;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq <= active ? prod : '0;
        end
    end

endmodule

/* sv/prts_sum_merge.sv */
// merges the lane squares into one saturated sum
`timescale 1ns / 1ps
module prts_sum_merge
    import prts_pkg::*;
#(
    parameter int LANES = MAX_COMP_DEF
)
(
    input  logic            clk,
    input  logic            en,
    input  logic [SQ_W-1:0] sq [LANES],
    output logic [SQ_W-1:0] sum
);

    logic [SQ_W+1:0] total;

    always_comb
    begin
        total = '0;
        for (int k = 0; k < LANES; k++)
        begin
            total = total + {2'b00, sq[k]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum <= (|total[SQ_W+1:SQ_W]) ? '1 : total[SQ_W-1:0];
        end
    end

endmodule

/* sv/prts_sqrt.sv */
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
module prts_sqrt
    import prts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  side_t             in_side,
    input  logic [SQ_W-1:0]   in_val,
    output logic              out_valid,
    output side_t             out_side,
    output logic [ROOT_W-1:0] root
);

    localparam int REM_W = ROOT_W + 4;

    logic              st_v    [ROOT_W+1];
    side_t             st_side [ROOT_W+1];
    logic [SQ_W-1:0]   st_val  [ROOT_W+1];
    logic [REM_W-1:0]  st_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] st_root [ROOT_W+1];

    assign st_v[0]    = in_valid;
    assign st_side[0] = in_side;
    assign st_val[0]  = in_val;
    assign st_rem[0]  = '0;
    assign st_root[0] = '0;

    genvar i;
    generate
        for (i = 0; i < ROOT_W; i++)
        begin : g_step
            logic [REM_W-1:0] rs;
            logic [REM_W-1:0] trial;
            logic             ge;

            // bring down the next two bits, try root*4+1
            assign rs    = {st_rem[i][REM_W-3:0], st_val[i][SQ_W-1:SQ_W-2]};
            assign trial = {2'b00, st_root[i], 2'b01};
            assign ge    = (rs >= trial);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    st_v[i+1] <= 1'b0;
                end
                else if (en)
                begin
                    st_v[i+1] <= st_v[i];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    st_side[i+1] <= st_side[i];
                    st_val[i+1]  <= {st_val[i][SQ_W-3:0], 2'b00};
                    st_rem[i+1]  <= ge ? (rs - trial) : rs;
                    st_root[i+1] <= {st_root[i][ROOT_W-2:0], ge};
                end
            end
        end
    endgenerate

    assign out_valid = st_v[ROOT_W];
    assign out_side  = st_side[ROOT_W];
    assign root      = st_root[ROOT_W];

endmodule

/* sv/particle_radius_table_scaler.sv */
// an item passes the lane squares, the merged sum, the root stages, stages c to j and the output register
// throughput: one item per cycle while the output skid slot is free, the root unit retires one bit per stage
// a two-entry output buffer keeps input open for one item while a result waits
// reset clears valid bits and loads configuration reset values
// table contents are undefined until written; table writes go in order with reads
`timescale 1ns / 1ps
`include "particle_radius_table_scaler_macros.svh"
module particle_radius_table_scaler
    import prts_pkg::*;
#(
    parameter int TABLE_SIZE     = TABLE_SIZE_DEF,
    parameter int MAX_COMPONENTS = MAX_COMP_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    // table_addr, table_value, comp0, comp1, comp2, comp3, comp_count, zero pad
    input  logic [IN_W-1:0]   s_tdata,
    // func
    input  logic              s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    // radius_out
    output logic [31:0]       m_tdata,
    // saturated
    output logic              m_tuser,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata
);

    localparam int LANES = (MAX_COMPONENTS < 4) ? MAX_COMPONENTS : 4;
    localparam int AW    = $clog2(TABLE_SIZE);

    // configuration
    logic               use_reg;
    logic signed [2:0]  csel_reg;
    logic [31:0]        ps_reg;
    logic               ten_reg;
    logic [31:0]        tis_reg;
    logic signed [31:0] tio_reg;
    logic [31:0]        sf_reg;
    logic [31:0]        ts_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_reg  <= 1'b0;
            csel_reg <= -3'sd1;
            ps_reg   <= Q16_ONE;
            ten_reg  <= 1'b0;
            tis_reg  <= Q16_ONE;
            tio_reg  <= '0;
            sf_reg   <= Q16_ONE;
            ts_reg   <= Q16_ONE;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_USE_SCALE: use_reg  <= cfg_wdata[0];
                REG_COMP_SEL:  csel_reg <= cfg_wdata[2:0];
                REG_POINT:     ps_reg   <= cfg_wdata;
                REG_TBL_EN:    ten_reg  <= cfg_wdata[0];
                REG_TBL_SCALE: tis_reg  <= cfg_wdata;
                REG_TBL_OFS:   tio_reg  <= cfg_wdata;
                REG_SCALE:     sf_reg   <= cfg_wdata;
                REG_TRI:       ts_reg   <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    // pipeline advances whenever the output skid slot is free
    logic en;
    logic k_v;
    assign en       = !k_v;
    assign s_tready = en;

    // input unpack and selection
    logic signed [31:0] comp [4];
    logic [2:0]         in_count;
    logic [2:0]         n_cnt;
    logic signed [2:0]  c_sel;
    logic               mag_sel;
    logic signed [32:0] sel_raw;
    side_t              in_side;

    assign comp[0]  = s_tdata[71:40];
    assign comp[1]  = s_tdata[103:72];
    assign comp[2]  = s_tdata[135:104];
    assign comp[3]  = s_tdata[167:136];
    assign in_count = s_tdata[170:168];

    always_comb
    begin
        if (in_count == 3'd0)
        begin
            n_cnt = 3'd1;
        end
        else if (in_count > 3'(LANES))
        begin
            n_cnt = 3'(LANES);
        end
        else
        begin
            n_cnt = in_count;
        end
        c_sel   = (n_cnt == 3'd1) ? 3'sd0 : csel_reg;
        mag_sel = use_reg && (c_sel[2] || ({1'b0, c_sel[1:0]} >= n_cnt));
        if (!use_reg)
        begin
            sel_raw = {1'b0, ps_reg};
        end
        else
        begin
            sel_raw = {comp[c_sel[1:0]][31], comp[c_sel[1:0]]};
        end
        in_side.func    = s_tuser;
        in_side.addr    = s_tdata[7:0];
        in_side.tval    = s_tdata[39:8];
        in_side.mag     = mag_sel;
        in_side.sel_raw = sel_raw;
    end

    // stage a: lane squares
    logic [SQ_W-1:0] sq [LANES];
    logic            a_v;
    side_t           a_side;

    genvar k;
    generate
        for (k = 0; k < LANES; k++)
        begin : g_lane
            prts_sq_lane u_lane (
                .clk    (clk),
                .en     (en),
                .comp   (comp[k]),
                .active (3'(k) < n_cnt),
                .sq     (sq[k])
            );
        end
    endgenerate

    // stage b: merged sum
    logic [SQ_W-1:0] b_sum;
    logic            b_v;
    side_t           b_side;

    prts_sum_merge #(.LANES(LANES)) u_merge (
        .clk (clk),
        .en  (en),
        .sq  (sq),
        .sum (b_sum)
    );

    // root stages
    logic              q_v;
    side_t             q_side;
    logic [ROOT_W-1:0] q_root;

    prts_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (b_v),
        .in_side   (b_side),
        .in_val    (b_sum),
        .out_valid (q_v),
        .out_side  (q_side),
        .root      (q_root)
    );

    // stage c: raw value and offset
    logic signed [32:0] raw_c;
    logic               c_v, c_func;
    logic [7:0]         c_addr;
    logic [31:0]        c_tval;
    logic signed [32:0] c_raw;
    logic signed [33:0] c_d;

    assign raw_c = q_side.mag ? $signed({1'b0, q_root}) : q_side.sel_raw;

    // stage d: index product
    logic               d_v, d_func, d_pos, d_hi;
    logic [7:0]         d_addr;
    logic [31:0]        d_tval;
    logic signed [32:0] d_raw;
    logic [63:0]        d_lo;
    logic [63:0]        idx_prod;

    assign idx_prod = c_d[31:0] * tis_reg;

    // stage e: table read
    logic [32:0]   ipart;
    logic [AW-1:0] ra_addr, rb_addr;
    logic [15:0]   f_next;
    logic          tbl_we;
    logic [31:0]   ra_data, rb_data;
    logic          e_v, e_func;
    logic signed [32:0] e_raw;
    logic [15:0]   e_f;

    always_comb
    begin
        ipart = {1'b0, (d_hi ? tis_reg : 32'd0)} + {1'b0, d_lo[63:32]};
        if (!d_pos)
        begin
            ra_addr = '0;
            rb_addr = '0;
            f_next  = '0;
        end
        else if (ipart >= 33'(TABLE_SIZE - 1))
        begin
            ra_addr = AW'(TABLE_SIZE - 1);
            rb_addr = AW'(TABLE_SIZE - 1);
            f_next  = '0;
        end
        else
        begin
            ra_addr = ipart[AW-1:0];
            rb_addr = ipart[AW-1:0] + 1'b1;
            f_next  = d_lo[31:16];
        end
    end

    // write items land at the same point where radius items read
    assign tbl_we = en && d_v && !d_func && ({24'd0, d_addr} < 32'(TABLE_SIZE));

    prts_ram #(.WIDTH(32), .DEPTH(TABLE_SIZE)) u_ram_a (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (AW'(d_addr)),
        .wdata (d_tval),
        .re    (en),
        .raddr (ra_addr),
        .rdata (ra_data)
    );

    prts_ram #(.WIDTH(32), .DEPTH(TABLE_SIZE)) u_ram_b (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (AW'(d_addr)),
        .wdata (d_tval),
        .re    (en),
        .raddr (rb_addr),
        .rdata (rb_data)
    );

    // stage f: interpolation products
    logic               f_v, f_func;
    logic signed [32:0] f_raw;
    logic signed [49:0] f_pa, f_pb;
    logic [16:0]        w_a;

    assign w_a = 17'h10000 - {1'b0, e_f};

    // stage g: interpolated or raw value
    logic signed [49:0] interp_sum;
    logic               g_v, g_func;
    logic signed [33:0] g_raw;

    assign interp_sum = f_pa + f_pb;

    // stage h: first multiplier
    logic        h_v, h_func, h_pos;
    logic [47:0] h_m1;
    logic [63:0] m1_prod;

    assign m1_prod = g_raw[31:0] * sf_reg;

    // stage i: second multiplier in two partial products
    logic        i_v, i_func, i_pos;
    logic [47:0] i_hi;
    logic [63:0] i_lo;

    // stage j: recombine and saturate at 2^48
    logic [48:0] r_sum;
    logic        r_sat48;
    logic        j_v, j_func;
    logic [48:0] j_r;

    assign r_sum   = {1'b0, i_hi[31:0], 16'd0} + {1'b0, i_lo[63:16]};
    assign r_sat48 = (|i_hi[47:32]) || (r_sum > {1'b1, 48'd0});

    // result shaping: small values scaled by 100 then floored
    logic [13:0] small_r;
    logic [48:0] r1, r2;
    logic        new_sat;
    logic [31:0] new_data;
    logic        new_v;

    always_comb
    begin
        small_r  = j_r[6:0] * RADIUS_GAIN;
        r1       = (j_r < 49'(RADIUS_FLOOR)) ? 49'(small_r) : j_r;
        r2       = (r1 < 49'(RADIUS_FLOOR)) ? 49'(RADIUS_FLOOR) : r1;
        new_sat  = |r2[48:32];
        new_data = new_sat ? 32'hFFFF_FFFF : r2[31:0];
        new_v    = j_v && j_func;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v <= 1'b0;
            b_v <= 1'b0;
            c_v <= 1'b0;
            d_v <= 1'b0;
            e_v <= 1'b0;
            f_v <= 1'b0;
            g_v <= 1'b0;
            h_v <= 1'b0;
            i_v <= 1'b0;
            j_v <= 1'b0;
        end
        else if (en)
        begin
            a_v <= s_tvalid;
            b_v <= a_v;
            c_v <= q_v;
            d_v <= c_v;
            e_v <= d_v;
            f_v <= e_v;
            g_v <= f_v;
            h_v <= g_v;
            i_v <= h_v;
            j_v <= i_v;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_side <= in_side;
            b_side <= a_side;

            c_func <= q_side.func;
            c_addr <= q_side.addr;
            c_tval <= q_side.tval;
            c_raw  <= raw_c;
            c_d    <= {raw_c[32], raw_c} - {{2{tio_reg[31]}}, tio_reg};

            d_func <= c_func;
            d_addr <= c_addr;
            d_tval <= c_tval;
            d_raw  <= c_raw;
            d_pos  <= !c_d[33] && (|c_d);
            d_hi   <= c_d[32];
            d_lo   <= idx_prod;

            e_func <= d_func;
            e_raw  <= d_raw;
            e_f    <= f_next;

            f_func <= e_func;
            f_raw  <= e_raw;
            f_pa   <= $signed(ra_data) * $signed({1'b0, w_a});
            f_pb   <= $signed(rb_data) * $signed({2'b00, e_f});

            g_func <= f_func;
            g_raw  <= ten_reg ? interp_sum[49:16] : {f_raw[32], f_raw};

            h_func <= g_func;
            h_pos  <= !g_raw[33] && (|g_raw);
            h_m1   <= m1_prod[63:16];

            i_func <= h_func;
            i_pos  <= h_pos;
            i_hi   <= h_m1[47:32] * ts_reg;
            i_lo   <= h_m1[31:0] * ts_reg;

            j_func <= i_func;
            if (!i_pos)
            begin
                j_r <= '0;
            end
            else
            begin
                j_r <= r_sat48 ? {1'b1, 48'd0} : r_sum;
            end
        end
    end

    // output register with one skid entry
    logic        o_v;
    logic [31:0] o_data, k_data;
    logic        o_sat, k_sat;
    logic        take, arrive;

    assign take   = o_v && m_tready;
    assign arrive = en && new_v;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_v    <= 1'b0;
            k_v    <= 1'b0;
            o_data <= '0;
            o_sat  <= 1'b0;
            k_data <= '0;
            k_sat  <= 1'b0;
        end
        else if (k_v)
        begin
            if (take)
            begin
                o_data <= k_data;
                o_sat  <= k_sat;
                k_v    <= 1'b0;
            end
        end
        else if (arrive)
        begin
            if (!o_v || take)
            begin
                o_v    <= 1'b1;
                o_data <= new_data;
                o_sat  <= new_sat;
            end
            else
            begin
                k_v    <= 1'b1;
                k_data <= new_data;
                k_sat  <= new_sat;
            end
        end
        else if (take)
        begin
            o_v <= 1'b0;
        end
    end

    assign m_tvalid = o_v;
    assign m_tdata  = o_data;
    assign m_tuser  = o_sat;

    `PRTS_ASSERT_IMPL(a_skid_needs_out, clk, rst_n, k_v, o_v, "skid item without output item")
    `PRTS_ASSERT_IMPL(a_radius_floor, clk, rst_n, m_tvalid, m_tdata >= 32'd66, "radius below floor")
    `PRTS_ASSERT_IMPL(a_sat_is_max, clk, rst_n, m_tvalid && m_tuser, m_tdata == 32'hFFFF_FFFF, "saturated item not at maximum")
    `PRTS_ASSERT_NEXT(a_skid_drains, clk, rst_n, k_v && m_tready, !k_v && o_v, "skid did not drain into output")

endmodule

/* dv/tb.sv */
// self-checking testbench for the particle radius table scaler
`timescale 1ns / 1ps
module tb;
    import prts_pkg::*;

    localparam int LATENCY = 43;

    typedef struct {
        logic        func;
        logic [7:0]  addr;
        logic [31:0] tval;
        logic [31:0] comp [4];
        logic [2:0]  count;
        logic        chk;
        logic [31:0] exp_radius;
        logic        exp_sat;
    } stim_t;

    typedef struct {
        logic [31:0] radius;
        logic        sat;
    } radius_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [31:0]       m_tdata;
    logic              m_tuser;
    logic              cfg_we;
    logic [CFG_AW-1:0] cfg_addr;
    logic [CFG_DW-1:0] cfg_wdata;

    // predictor state
    logic [31:0]        tbl [256];
    logic               p_use_scale;
    logic signed [2:0]  p_comp_sel;
    logic [31:0]        p_point;
    logic               p_tbl_en;
    logic [31:0]        p_tbl_scale;
    logic signed [31:0] p_tbl_ofs;
    logic [31:0]        p_scale;
    logic [31:0]        p_tri;

    radius_t     radius_q [$];
    int          errors;
    int          long_hold;
    stim_t       dir [$];

    particle_radius_table_scaler u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] q16_mul_sat(logic [63:0] a, logic [31:0] m);
        logic [127:0] p;
        p = (128'(a) * m) >> 16;
        return (p > (128'd1 << 48)) ? (64'd1 << 48) : p[63:0];
    endfunction

    function automatic logic signed [63:0] tbl_interp(logic signed [63:0] raw);
        logic signed [63:0] d;
        logic [95:0]        t;
        logic [63:0]        ip;
        logic [63:0]        f;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] v;
        d = raw - 64'(p_tbl_ofs);
        if (d <= 0)
            return 64'(signed'(tbl[0]));
        t = 96'(d) * p_tbl_scale;
        ip = t[95:32];
        if (ip >= 255)
            return 64'(signed'(tbl[255]));
        f = t[31:16];
        a = 64'(signed'(tbl[ip]));
        b = 64'(signed'(tbl[ip + 1]));
        v = a * signed'(65536 - f) + b * signed'(f);
        return v >>> 16;
    endfunction

    function automatic radius_t radius_predict(stim_t s);
        radius_t            r;
        logic signed [63:0] raw;
        logic [63:0]        acc;
        logic [64:0]        sum;
        logic [63:0]        sq;
        logic signed [63:0] x;
        int                 n;
        int                 c;
        if (p_use_scale)
        begin
            n = (s.count == 0) ? 1 : (s.count > 4 ? 4 : s.count);
            c = (n == 1) ? 0 : p_comp_sel;
            if (c < 0 || c >= n)
            begin
                sum = 0;
                for (int k = 0; k < n; k++)
                begin
                    x = 64'(signed'(s.comp[k]));
                    if (x < 0)
                        x = -x;
                    sq = x * x;
                    sum = sum + sq;
                    if (sum[64])
                        sum = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
                end
                raw = isqrt(sum[63:0]);
            end
            else
                raw = 64'(signed'(s.comp[c]));
        end
        else
            raw = 64'(p_point);
        if (p_tbl_en)
            raw = tbl_interp(raw);
        acc = 0;
        if (raw > 0)
            acc = q16_mul_sat(q16_mul_sat(raw, p_scale), p_tri);
        if (acc < 66)
            acc *= 100;
        if (acc < 66)
            acc = 66;
        r.sat = acc > 64'hFFFF_FFFF;
        r.radius = r.sat ? 32'hFFFF_FFFF : acc[31:0];
        return r;
    endfunction

    task automatic cfg_write(logic [CFG_AW-1:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_USE_SCALE: p_use_scale = val[0];
            REG_COMP_SEL:  p_comp_sel = val[2:0];
            REG_POINT:     p_point = val;
            REG_TBL_EN:    p_tbl_en = val[0];
            REG_TBL_SCALE: p_tbl_scale = val;
            REG_TBL_OFS:   p_tbl_ofs = val;
            REG_SCALE:     p_scale = val;
            default:       p_tri = val;
        endcase
        @(negedge clk);
    endtask

    // wait for every result, then let a write still in flight drain
    task automatic drain();
        s_tvalid <= 1'b0;
        while (radius_q.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    task automatic send(stim_t s);
        radius_t r;
        int      gap;
        gap = $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= s.func;
        s_tdata <= {5'd0, s.count, s.comp[3], s.comp[2], s.comp[1], s.comp[0],
                    s.tval, s.addr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (s.func)
        begin
            r = radius_predict(s);
            if (s.chk && (r.radius !== s.exp_radius || r.sat !== s.exp_sat))
            begin
                errors++;
                $display("table row wrong: model %h/%b typed %h/%b",
                         r.radius, r.sat, s.exp_radius, s.exp_sat);
            end
            radius_q.push_back(r);
        end
        else
        begin
            tbl[s.addr] = s.tval;
        end
        @(negedge clk);
    endtask

    function automatic stim_t mk(logic func, logic [7:0] addr, logic [31:0] tval,
                                 logic [31:0] c0, logic [31:0] c1, logic [31:0] c2,
                                 logic [31:0] c3, logic [2:0] cnt, logic chk,
                                 logic [31:0] er, logic es);
        stim_t s;
        s.func = func;
        s.addr = addr;
        s.tval = tval;
        s.comp[0] = c0;
        s.comp[1] = c1;
        s.comp[2] = c2;
        s.comp[3] = c3;
        s.count = cnt;
        s.chk = chk;
        s.exp_radius = er;
        s.exp_sat = es;
        return s;
    endfunction

    function automatic stim_t rnd_item(int wr_pct);
        stim_t s;
        s.func = ($urandom_range(0, 99) >= wr_pct);
        s.addr = 8'($urandom);
        s.tval = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0008_0000);
        for (int k = 0; k < 4; k++)
            case ($urandom_range(0, 3))
                0: s.comp[k] = $urandom;
                1: s.comp[k] = $urandom_range(0, 32'h0004_0000);
                2: s.comp[k] = -$urandom_range(0, 32'h0004_0000);
                default: s.comp[k] = $urandom_range(0, 200);
            endcase
        s.count = 3'($urandom);
        s.chk = 1'b0;
        s.exp_radius = 0;
        s.exp_sat = 0;
        return s;
    endfunction

    function automatic logic [31:0] rnd_q16();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 100);
            default: return $urandom_range(32'h0000_4000, 32'h0004_0000);
        endcase
    endfunction

    // result checker, with random stall and one long hold-off
    initial
    begin
        radius_t e;
        int      shown;
        int      wait_cyc;
        shown = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (long_hold) @(negedge clk);
                long_hold = 0;
            end
            wait_cyc = $urandom_range(0, 5);
            if (wait_cyc > 0)
            begin
                m_tready <= 1'b0;
                repeat (wait_cyc) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            if (radius_q.size() == 0)
            begin
                errors++;
                if (shown++ < 10)
                    $display("unexpected radius item %h/%b", m_tdata, m_tuser);
            end
            else
            begin
                e = radius_q.pop_front();
                if (m_tdata !== e.radius || m_tuser !== e.sat)
                begin
                    errors++;
                    if (shown++ < 10)
                        $display("radius mismatch: expected %h sat %b, got %h sat %b",
                                 e.radius, e.sat, m_tdata, m_tuser);
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        stim_t s;
        int    sent;
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        errors = 0;
        long_hold = 0;
        p_use_scale = 0;
        p_comp_sel = -1;
        p_point = Q16_ONE;
        p_tbl_en = 0;
        p_tbl_scale = Q16_ONE;
        p_tbl_ofs = 0;
        p_scale = Q16_ONE;
        p_tri = Q16_ONE;
        for (int i = 0; i < 256; i++)
        begin
            tbl[i] = 0;
        end
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // after reset: point size 1.0 through unit scales
        dir.push_back(mk(1, 0, 0, 0, 0, 0, 0, 1, 1, Q16_ONE, 0));
        // fill the whole table so every read is defined
        for (int i = 0; i < 256; i++)
            dir.push_back(mk(0, 8'(i), 32'(i) << 16, 0, 0, 0, 0, 1, 0, 0, 0));
        foreach (dir[i])
            send(dir[i]);
        dir.delete();
        drain();

        cfg_write(REG_USE_SCALE, 1);
        // single component, magnitude, zero and negative, extremes
        dir.push_back(mk(1, 0, 0, 32'h0002_0000, 0, 0, 0, 1, 1, 32'h0002_0000, 0));
        dir.push_back(mk(1, 0, 0, 32'h0003_0000, 32'h0004_0000, 0, 0, 2, 1,
                         32'h0005_0000, 0));
        dir.push_back(mk(1, 0, 0, 0, 0, 0, 0, 1, 1, 66, 0));
        dir.push_back(mk(1, 0, 0, 32'hFFFF_0000, 0, 0, 0, 1, 1, 66, 0));
        dir.push_back(mk(1, 0, 0, 32'd1, 0, 0, 0, 1, 1, 100, 0));
        dir.push_back(mk(1, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 1, 1, 32'h7FFF_FFFF, 0));
        dir.push_back(mk(1, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000, 4, 1, 32'hFFFF_FFFF, 0));
        dir.push_back(mk(1, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                         32'h0001_0000, 0, 1, 32'h0001_0000, 0));
        dir.push_back(mk(1, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                         32'h0001_0000, 7, 0, 0, 0));
        foreach (dir[i])
            send(dir[i]);
        dir.delete();
        drain();

        cfg_write(REG_COMP_SEL, 3);
        cfg_write(REG_TBL_EN, 1);
        cfg_write(REG_TBL_OFS, 32'hFFFF_0000);
        // below the table start, inside, and past its end
        dir.push_back(mk(1, 0, 0, 0, 0, 0, 32'h8000_0000, 4, 0, 0, 0));
        dir.push_back(mk(1, 0, 0, 0, 0, 0, 32'h0002_8000, 4, 0, 0, 0));
        dir.push_back(mk(1, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 4, 1, 32'h00FF_0000, 0));
        dir.push_back(mk(1, 0, 0, 32'h0005_0000, 0, 0, 0, 3, 0, 0, 0));
        foreach (dir[i])
            send(dir[i]);
        dir.delete();
        drain();

        // random phases, each with its own register setting
        sent = 0;
        for (int ph = 0; ph < 12; ph++)
        begin
            cfg_write(REG_USE_SCALE, (ph % 4) != 3);
            cfg_write(REG_COMP_SEL, $urandom_range(0, 7));
            cfg_write(REG_POINT, (ph == 3) ? 32'hFFFF_FFFF : rnd_q16());
            cfg_write(REG_TBL_EN, ph[0]);
            cfg_write(REG_TBL_SCALE, (ph == 5) ? 32'h0 : rnd_q16());
            cfg_write(REG_TBL_OFS, (ph == 7) ? 32'h8000_0000 :
                      (ph == 9) ? 32'h7FFF_FFFF : $urandom_range(0, 1) ? $urandom : 0);
            cfg_write(REG_SCALE, (ph == 2) ? 32'h0 : (ph == 4) ? 32'hFFFF_FFFF :
                      rnd_q16());
            cfg_write(REG_TRI, (ph == 6) ? 32'hFFFF_FFFF : rnd_q16());
            if (ph == 4)
                long_hold = 300;
            for (int i = 0; i < 65; i++)
            begin
                s = rnd_item(15);
                send(s);
                sent++;
                // sender pause until everything is back
                if (ph == 8 && i == 30)
                begin
                    s_tvalid <= 1'b0;
                    @(negedge clk);
                    while (radius_q.size() != 0)
                        @(negedge clk);
                end
            end
            drain();
        end
        drain();
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+sv
sv/prts_pkg.sv
sv/prts_ram.sv
sv/prts_sq_lane.sv
sv/prts_sum_merge.sv
sv/prts_sqrt.sv
sv/particle_radius_table_scaler.sv
dv/tb.sv
